### src/hgfc_pkg.sv
// Shared constants, codes and types of the heightmap gap fill block.
`timescale 1ns / 1ps

package hgfc_pkg;

   // Map geometry and line stores.
   localparam int MAX_MAP_SIZE = 256;
   localparam int ADDR_W       = $clog2(MAX_MAP_SIZE);
   localparam int ROW_W        = $clog2(MAX_MAP_SIZE + 1);

   // Field widths.
   localparam int HEIGHT_W  = 8;
   localparam int CELL_W    = 8;
   localparam int SECT_W    = 14;
   localparam int MAP_W     = 9;
   localparam int CUBE_W    = 7;
   localparam int SEC_LEN_W = 15;
   localparam int LIMIT_W   = HEIGHT_W + 1;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_SIZE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CUBE_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEC_LENGTH  = 2'd2;

   // Register reset values and clamps.
   localparam logic [MAP_W-1:0]     MAP_SIZE_RESET = MAP_W'(256);
   localparam logic [CUBE_W-1:0]    CUBE_RESET     = CUBE_W'(4);
   localparam logic [SEC_LEN_W-1:0] SEC_LEN_RESET  = SEC_LEN_W'(64);
   localparam logic [MAP_W-1:0]     MAP_MIN        = MAP_W'(2);
   localparam logic [MAP_W-1:0]     MAP_MAX        = MAP_W'(MAX_MAP_SIZE);
   localparam logic [CUBE_W-1:0]    CUBE_MIN       = CUBE_W'(4);
   localparam logic [CUBE_W-1:0]    CUBE_MAX       = CUBE_W'(64);

   // Input selector codes.
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_FLUSH  = 1'b1;

   // Stream payload widths.
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USED_W = 4 * CELL_W + 2 * SECT_W;

   // Section divider: two quotient bits per cycle.
   localparam int DIV_W     = 16;
   localparam int DIV_STEPS = DIV_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_WRITE,
      ST_READ_A,
      ST_READ_B,
      ST_CALC,
      ST_WAIT_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;      // latch the incoming item
      logic capture;     // latch cell coordinates and edge flags
      logic store_wr;    // write the sample into the older line store
      logic advance;     // step column, row and bank counters
      logic read_near;   // read the cell and its south neighbor, start dividers
      logic read_north;  // capture near reads, read the north neighbor
      logic calc;        // form the fill limit and the running height
      logic emit;        // load one fill cube into the output register
   } cmd_type;

   typedef struct packed {
      logic is_sample;   // latched item is a height sample
      logic row_full;    // all rows of the map have arrived
      logic row_zero;    // no row has arrived yet
      logic div_done;    // section indices are ready
      logic more;        // running height still above the limit
      logic out_free;    // output register can take a cube this cycle
   } stat_type;

endpackage

### src/hgfc_div.sv
// Iterative unsigned divider for the section indices, two bits per cycle.
`timescale 1ns / 1ps

module hgfc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [hgfc_pkg::DIV_W-1:0]     dividend,
   input  logic [hgfc_pkg::SEC_LEN_W-1:0] divisor,
   output logic [hgfc_pkg::DIV_W-1:0]     quotient,
   output logic                          done
);
   import hgfc_pkg::*;

   logic [SEC_LEN_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;

   // One restoring step: shift in one dividend bit, subtract when it fits.
   function automatic logic [SEC_LEN_W:0] div_step(input logic [SEC_LEN_W-1:0] r,
                                                   input logic b,
                                                   input logic [SEC_LEN_W-1:0] d);
      logic [SEC_LEN_W:0] t;
      logic               q;
      t = {r, b};
      q = 1'b0;
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
         q = 1'b1;
      end
      return {q, t[SEC_LEN_W-1:0]};
   endfunction

   always_comb begin
      logic [SEC_LEN_W:0] s1;
      logic [SEC_LEN_W:0] s2;
      s1      = div_step(rem_ff, quo_ff[DIV_W-1], divisor);
      s2      = div_step(s1[SEC_LEN_W-1:0], quo_ff[DIV_W-2], divisor);
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = s2[SEC_LEN_W-1:0];
         quo_in = {quo_ff[DIV_W-3:0], s1[SEC_LEN_W], s2[SEC_LEN_W]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = ~busy_ff;

endmodule

### src/hgfc_datapath.sv
// Datapath: configuration, line stores, counters, neighbor minimum and cube output.
`timescale 1ns / 1ps

module hgfc_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  hgfc_pkg::cmd_type              cmd,
   output hgfc_pkg::stat_type             stat,
   input  logic                           csr_we,
   input  logic [hgfc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hgfc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [hgfc_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic [hgfc_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [hgfc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);
   import hgfc_pkg::*;

   // Configuration registers and their clamped values.
   logic [MAP_W-1:0]     map_size_ff;
   logic [CUBE_W-1:0]    cube_ff;
   logic [SEC_LEN_W-1:0] sec_ff;
   logic [MAP_W-1:0]     n_eff;
   logic [CUBE_W-1:0]    cl_eff;
   logic [SEC_LEN_W-1:0] sl_eff;

   // Counters.
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic              bank_ff, bank_in;

   // Latched item and cell.
   logic                func_ff;
   logic [HEIGHT_W-1:0] hin_ff;
   logic [CELL_W-1:0]   x_ff;
   logic [ADDR_W-1:0]   z_ff;
   logic                has_west_ff;
   logic                has_east_ff;

   // Line stores.
   logic [HEIGHT_W-1:0] store_a [MAX_MAP_SIZE];
   logic [HEIGHT_W-1:0] store_b [MAX_MAP_SIZE];
   logic [ADDR_W-1:0]   ra0, ra1;
   logic [HEIGHT_W-1:0] rd0_a_ff, rd1_a_ff, rd0_b_ff, rd1_b_ff;
   logic [HEIGHT_W-1:0] prev_rd0, prev_rd1, other_rd0;

   // Neighbor values and fill state.
   logic [HEIGHT_W-1:0] c_ff, south_ff, west_ff;
   logic [HEIGHT_W-1:0] nv, sv, wv, ev, m01, m23, mmin;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [HEIGHT_W-1:0] h_ff;
   logic [LIMIT_W-1:0]  h_next;

   // Section dividers.
   logic [DIV_W-1:0] sx_q, sz_q;
   logic             sx_done, sz_done;
   logic [DIV_W-1:0] x_prod, z_prod;

   // Output register.
   logic                out_valid_ff;
   logic [CELL_W-1:0]   o_x_ff, o_z_ff;
   logic [HEIGHT_W-1:0] o_bot_ff, o_top_ff;
   logic [SECT_W-1:0]   o_sx_ff, o_sz_ff;
   logic                o_last_ff;

   always_comb begin
      n_eff = map_size_ff;
      if (map_size_ff < MAP_MIN) begin
         n_eff = MAP_MIN;
      end else if (map_size_ff > MAP_MAX) begin
         n_eff = MAP_MAX;
      end
      cl_eff = cube_ff;
      if (cube_ff < CUBE_MIN) begin
         cl_eff = CUBE_MIN;
      end else if (cube_ff > CUBE_MAX) begin
         cl_eff = CUBE_MAX;
      end
      sl_eff = (sec_ff == '0) ? SEC_LEN_W'(1) : sec_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_size_ff <= MAP_SIZE_RESET;
         cube_ff     <= CUBE_RESET;
         sec_ff      <= SEC_LEN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAP_SIZE:    map_size_ff <= csr_wdata[MAP_W-1:0];
            CSR_CUBE_LENGTH: cube_ff     <= csr_wdata[CUBE_W-1:0];
            CSR_SEC_LENGTH:  sec_ff      <= csr_wdata[SEC_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Counter stepping after a cell, and restart on a map size write.
   always_comb begin
      logic row_end;
      row_end = ({1'b0, z_ff} + 1'b1) >= n_eff;
      row_in  = row_ff;
      col_in  = col_ff;
      bank_in = bank_ff;
      if (csr_we && (csr_index == CSR_MAP_SIZE)) begin
         row_in  = '0;
         col_in  = '0;
         bank_in = 1'b0;
      end else if (cmd.advance) begin
         if (!row_end) begin
            col_in = z_ff + 1'b1;
         end else if (func_ff == FUNC_SAMPLE) begin
            col_in  = '0;
            bank_in = ~bank_ff;
            row_in  = row_ff + 1'b1;
         end else begin
            col_in  = '0;
            bank_in = 1'b0;
            row_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         bank_ff <= 1'b0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         bank_ff <= bank_in;
      end
   end

   // Item and cell latches.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_tuser[0];
         hin_ff  <= req_tdata[HEIGHT_W-1:0];
      end
      if (cmd.capture) begin
         z_ff <= (col_ff >= n_eff[ADDR_W-1:0] && n_eff != MAP_MAX) ? '0 : col_ff;
         if (func_ff == FUNC_SAMPLE) begin
            x_ff        <= CELL_W'(row_ff - 1'b1);
            has_west_ff <= (row_ff > ROW_W'(1));
            has_east_ff <= 1'b1;
         end else begin
            x_ff        <= CELL_W'(n_eff - 1'b1);
            has_west_ff <= 1'b1;
            has_east_ff <= 1'b0;
         end
      end
   end

   // Line stores: the previous row sits in the bank that bank_ff selects.
   assign ra0 = cmd.read_north ? (z_ff - 1'b1) : z_ff;
   assign ra1 = z_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.store_wr && bank_ff) begin
         store_a[z_ff] <= hin_ff;
      end
      rd0_a_ff <= store_a[ra0];
      rd1_a_ff <= store_a[ra1];
   end

   always_ff @(posedge clock) begin
      if (cmd.store_wr && !bank_ff) begin
         store_b[z_ff] <= hin_ff;
      end
      rd0_b_ff <= store_b[ra0];
      rd1_b_ff <= store_b[ra1];
   end

   assign prev_rd0  = bank_ff ? rd0_b_ff : rd0_a_ff;
   assign prev_rd1  = bank_ff ? rd1_b_ff : rd1_a_ff;
   assign other_rd0 = bank_ff ? rd0_a_ff : rd0_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.read_north) begin
         c_ff     <= prev_rd0;
         south_ff <= prev_rd1;
         west_ff  <= other_rd0;
      end
   end

   // Lowest neighbor; a neighbor past the edge counts as the cell itself.
   always_comb begin
      nv   = (z_ff == '0) ? c_ff : prev_rd0;
      sv   = (({1'b0, z_ff} + 1'b1) < n_eff) ? south_ff : c_ff;
      wv   = has_west_ff ? west_ff : c_ff;
      ev   = has_east_ff ? hin_ff : c_ff;
      m01  = (sv < nv) ? sv : nv;
      m23  = (ev < wv) ? ev : wv;
      mmin = (m23 < m01) ? m23 : m01;
   end

   assign h_next = {1'b0, h_ff} - LIMIT_W'(cl_eff);

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         limit_ff <= {1'b0, mmin} + LIMIT_W'(cl_eff);
         h_ff     <= c_ff;
      end else if (cmd.emit) begin
         h_ff <= h_next[HEIGHT_W-1:0];
      end
   end

   // Section indices of the cell.
   assign x_prod = DIV_W'(x_ff) * DIV_W'(cl_eff);
   assign z_prod = DIV_W'(z_ff) * DIV_W'(cl_eff);

   hgfc_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.read_near),
      .dividend (x_prod),
      .divisor  (sl_eff),
      .quotient (sx_q),
      .done     (sx_done)
   );

   hgfc_div u_div_z (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.read_near),
      .dividend (z_prod),
      .divisor  (sl_eff),
      .quotient (sz_q),
      .done     (sz_done)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         o_x_ff    <= x_ff;
         o_z_ff    <= CELL_W'(z_ff);
         o_bot_ff  <= h_next[HEIGHT_W-1:0];
         o_top_ff  <= h_ff;
         o_sx_ff   <= sx_q[SECT_W-1:0];
         o_sz_ff   <= sz_q[SECT_W-1:0];
         o_last_ff <= ~(h_next > limit_ff);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_USED_W){1'b0}},
                        o_sz_ff, o_sx_ff, o_top_ff, o_bot_ff, o_z_ff, o_x_ff};

   assign stat.is_sample = (func_ff == FUNC_SAMPLE);
   assign stat.row_full  = (MAP_W'(row_ff) >= n_eff);
   assign stat.row_zero  = (row_ff == '0);
   assign stat.div_done  = sx_done & sz_done;
   assign stat.more      = ({1'b0, h_ff} > limit_ff);
   assign stat.out_free  = ~out_valid_ff | rsp_tready;

endmodule

### src/hgfc_ctrl.sv
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps

module hgfc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  hgfc_pkg::stat_type  stat,
   output hgfc_pkg::cmd_type   cmd
);
   import hgfc_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (stat.is_sample) begin
               if (stat.row_full) begin
                  state_in = ST_IDLE;
               end else if (stat.row_zero) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_READ_A;
               end
            end else begin
               state_in = stat.row_full ? ST_READ_A : ST_IDLE;
            end
         end
         ST_WRITE:  state_in = ST_IDLE;
         ST_READ_A: state_in = ST_READ_B;
         ST_READ_B: state_in = ST_CALC;
         ST_CALC:   state_in = ST_WAIT_DIV;
         ST_WAIT_DIV: begin
            if (stat.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!stat.more) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_DECIDE: cmd.capture = 1'b1;
         ST_WRITE: begin
            cmd.store_wr = 1'b1;
            cmd.advance  = 1'b1;
         end
         ST_READ_A: cmd.read_near  = 1'b1;
         ST_READ_B: cmd.read_north = 1'b1;
         ST_CALC: begin
            cmd.calc     = 1'b1;
            cmd.advance  = 1'b1;
            cmd.store_wr = stat.is_sample;
         end
         ST_WAIT_DIV: ;
         ST_EMIT: cmd.emit = stat.more & stat.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/heightmap_gap_fill_cubes.sv
// Top level of the heightmap gap fill block: controller plus datapath.
`timescale 1ns / 1ps
//
//   channel  ports                        direction  content
//   req      req_tvalid/tready/tdata/tuser  in         one height sample or flush item
//   rsp      rsp_tvalid/tready/tdata/tlast  out        the fill cubes of each judged cell
//   csr      csr_we/index/wdata            in         register writes, no read-back
//
// An item that is dropped (a sample after the full map, an early flush) goes from
// decide straight back to idle, and a sample of the first row only adds the store
// write. An item that judges a cell passes the store reads and the limit calculation,
// waits on the two-bit-per-cycle section divider, and then emits its fill cubes
// before it leaves the emit loop.
// Reset is synchronous and active high; the line stores are not cleared, since
// the raster order writes every entry before it is read.
// The output register holds a cube while rsp_tready is low; the next item is
// accepted meanwhile, and its first cube waits for that register to drain.

module heightmap_gap_fill_cubes (
   input  logic                           clock,
   input  logic                           reset,
   // Configuration write port.
   input  logic                           csr_we,
   input  logic [hgfc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hgfc_pkg::CSR_DATA_W-1:0] csr_wdata,
   // Input items.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata: height [7:0]
   input  logic [hgfc_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: func [0] (0 = height sample, 1 = flush)
   input  logic [hgfc_pkg::REQ_USER_W-1:0] req_tuser,
   // Result items.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata: cell_x [7:0], cell_z [15:8], cube_bottom [23:16], cube_top [31:24],
   //        section_x [45:32], section_z [59:46], zero [63:60]
   output logic [hgfc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tlast: set on the final fill cube of a cell
   output logic                           rsp_tlast
);
   import hgfc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // The controller walks each item through decide, store reads, limit
   // calculation and the emit loop.
   hgfc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath holds configuration, the two line stores, the counters,
   // the section dividers and the output register.
   hgfc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
